@@ design/aic_pkg.sv @@
// Shared types and constants for the audio input conditioner.
// Holds request payload structs, sequencer state enum and fixed constants.
// No dependencies.
package aic_pkg;

    localparam logic [15:0] DISCARD_RESET = 16'd8000;
    localparam logic [15:0] POT_RESET     = 16'd16;
    localparam logic [10:0] GAIN_FLOOR    = 11'd128;
    localparam logic [16:0] POT_POLE      = 17'd4095;
    localparam logic [16:0] PEAK_POLE     = 17'd32767;
    localparam logic [16:0] CENTER        = 17'd32768;
    localparam logic [15:0] MONITOR_MID   = 16'd32767;
    localparam logic [11:0] DEMOD_MID     = 12'd2048;
    localparam logic [15:0] PEAK_MAX      = 16'd32768;

    typedef struct packed {
        logic [15:0] pot_level;
        logic [15:0] signal_level;
    } t_in;

    typedef struct packed {
        logic [15:0] monitor_level;
        logic [11:0] demod_sample;
        logic [15:0] peak_level;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POT,
        S_SPOT,
        S_GAIN,
        S_DIFF,
        S_SCALE,
        S_SAT,
        S_PEAK,
        S_OUT
    } t_state;

endpackage

@@ design/audio_input_conditioner_unit.sv @@
// Audio input conditioner: pot smoothing, squared gain, DC blocker, peak follower.
// One shared signed multiplier is stepped by a small sequencer.
// Depends on aic_pkg.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------
//  in       | into      | i_in_valid / o_in_stall   | i_in_data  (t_in)
//  out      | out of    | o_out_valid / i_out_stall | o_out_data (t_out)
//  cfg      | into      | i_cfg_we                  | i_cfg_data (discard count)
//
// A processed request reaches the output register after the four passes through the
// single multiplier plus the adds between them; the next request can be accepted once
// the sequencer is back in idle. A discarded request leaves the sequencer idle, ready
// for the next request. Reset is synchronous, active low, and loads the discard count
// with 8000. The output register lets a new request be accepted while a result is still
// stalled; a second result waits in the last step until the output register frees up.
module audio_input_conditioner_unit
    import aic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [15:0]        r_discard_left;
    logic [15:0]        r_pot;
    logic signed [16:0] r_x;
    logic [15:0]        r_spot;
    logic signed [31:0] r_acc;
    logic [10:0]        r_gain;
    logic signed [17:0] r_d;
    logic signed [15:0] r_s;
    logic [15:0]        r_peak;
    logic signed [35:0] r_prod;
    logic               r_out_valid;
    t_out               r_out;

    logic signed [18:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [35:0] mul_p;
    logic               accept;
    logic               out_free;
    logic [28:0]        pot_sum;
    logic signed [27:0] scaled;
    logic signed [15:0] sat_s;
    logic [15:0]        rect;
    logic [31:0]        peak_sum;
    logic [15:0]        peak_new;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && r_discard_left == 16'd0) n_state = S_POT;
            S_POT:   n_state = S_SPOT;
            S_SPOT:  n_state = S_GAIN;
            S_GAIN:  n_state = S_DIFF;
            S_DIFF:  n_state = S_SCALE;
            S_SCALE: n_state = S_SAT;
            S_SAT:   n_state = S_PEAK;
            S_PEAK:  n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: stall and multiplier operand select
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            S_POT: begin
                mul_a = {3'b000, r_spot};
                mul_b = POT_POLE;
            end
            S_GAIN: begin
                mul_a = {4'b0000, r_spot[15:1]};
                mul_b = {1'b0, r_spot};
            end
            S_SCALE: begin
                mul_a = {r_d[17], r_d};
                mul_b = {6'b000000, r_gain};
            end
            // peak product held while the result waits for the output register
            S_PEAK, S_OUT: begin
                mul_a = {3'b000, r_peak};
                mul_b = PEAK_POLE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign pot_sum = r_prod[28:0] + {13'd0, r_pot};
    assign scaled  = r_prod[35:8];

    always_comb begin
        if (scaled > 28'sd32767)
            sat_s = 16'sh7fff;
        else if (scaled < -28'sd32768)
            sat_s = 16'sh8000;
        else
            sat_s = scaled[15:0];
    end

    // |-32768| wraps to 0x8000, which reads as 32768 unsigned
    assign rect     = r_s[15] ? 16'(-r_s) : 16'(r_s);
    assign peak_sum = {16'd0, rect} + r_prod[31:0];
    assign peak_new = (rect > r_peak) ? rect : peak_sum[30:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_discard_left <= DISCARD_RESET;
            r_spot         <= POT_RESET;
            r_acc          <= '0;
            r_peak         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (o_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;
            if (i_cfg_we)
                r_discard_left <= i_cfg_data;
            else if (accept && r_discard_left != 16'd0)
                r_discard_left <= r_discard_left - 16'd1;
            case (r_state)
                S_SPOT: begin
                    r_spot <= pot_sum[27:12];
                    r_acc  <= r_acc + 32'(r_x) - (r_acc >>> 15);
                end
                S_OUT: begin
                    if (out_free)
                        r_peak <= peak_new;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (accept) begin
            r_pot <= i_in_data.pot_level;
            r_x   <= CENTER - {1'b0, i_in_data.signal_level};
        end
        case (r_state)
            S_DIFF: begin
                r_gain <= {1'b0, r_prod[30:21]} + GAIN_FLOOR;
                r_d    <= {r_x[16], r_x} - {r_acc[31], r_acc[31:15]};
            end
            S_SAT: r_s <= sat_s;
            S_OUT: begin
                if (out_free) begin
                    r_out.monitor_level <= MONITOR_MID - r_s;
                    r_out.demod_sample  <= DEMOD_MID + r_s[15:4];
                    r_out.peak_level    <= peak_new;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_stall_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("request accepted while sequencer busy");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak <= PEAK_MAX)
        else $error("peak follower out of range");

    a_result_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished result not presented");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |-> (r_gain >= GAIN_FLOOR && r_gain <= 11'd1151))
        else $error("gain out of range");

endmodule
